FILE: rtl/dssm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dssm_pkg
// Shared types and codes for the dual stack that lives in one memory.
// ============================================================================
package dssm_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CMD_W         = 3;
    localparam int WORD_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_LOW  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_HIGH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LOW   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HIGH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic accept;
        logic read_en;
    } ctrl_cmd_t;

endpackage

FILE: rtl/dssm_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// dssm_ctrl
// Sequencer that accepts a command, schedules the top-of-stack read and
// raises the result strobe.
// ============================================================================
module dssm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output dssm_pkg::ctrl_cmd_t cmd
);
    import dssm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy        = (state_reg == S_READ);
    assign done        = (state_reg == S_RESP);
    assign cmd.accept  = start && !busy;
    assign cmd.read_en = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (cmd.accept)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_READ)
        else $error("An accepted command did not start a read.");

    a_read_responds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> done)
        else $error("A read was not followed by a result strobe.");

    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_READ))
        else $error("A result strobe appeared without a preceding read.");

endmodule

FILE: rtl/dssm_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// dssm_datapath
// Shared word memory, the two fill counters and the result registers.
// ============================================================================
module dssm_datapath
#(
    parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dssm_pkg::ctrl_cmd_t                  cmd,
    input  logic [dssm_pkg::CMD_W-1:0]           command,
    input  logic signed [dssm_pkg::WORD_W-1:0]   value,
    output logic [dssm_pkg::STATUS_W-1:0]        status,
    output logic signed [dssm_pkg::WORD_W-1:0]   low_top,
    output logic signed [dssm_pkg::WORD_W-1:0]   high_top,
    output logic [dssm_pkg::COUNT_W-1:0]         low_count,
    output logic [dssm_pkg::COUNT_W-1:0]         high_count
);
    import dssm_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]    low_fill_reg;
    logic [CNT_W-1:0]    low_fill_next;
    logic [CNT_W-1:0]    high_fill_reg;
    logic [CNT_W-1:0]    high_fill_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [WORD_W-1:0]   rd_low_reg;
    logic [WORD_W-1:0]   rd_high_reg;

    logic [CNT_W:0]      fill_sum;
    logic                full;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CNT_W-1:0]    high_push_pos;
    logic [CNT_W-1:0]    low_top_pos;
    logic [CNT_W-1:0]    high_top_pos;
    logic [ADDR_W-1:0]   rd_low_addr;
    logic [ADDR_W-1:0]   rd_high_addr;
    logic [CNT_W+COUNT_W-1:0] low_ext;
    logic [CNT_W+COUNT_W-1:0] high_ext;

    assign fill_sum      = {1'b0, low_fill_reg} + {1'b0, high_fill_reg};
    assign full          = fill_sum >= (CNT_W + 1)'(DEPTH);
    assign high_push_pos = CNT_W'(DEPTH - 1) - high_fill_reg;
    assign low_top_pos   = low_fill_reg - CNT_W'(1);
    assign high_top_pos  = CNT_W'(DEPTH) - high_fill_reg;
    assign rd_low_addr   = (low_fill_reg == '0) ? '0 : low_top_pos[ADDR_W-1:0];
    assign rd_high_addr  = (high_fill_reg == '0) ? '0 : high_top_pos[ADDR_W-1:0];

    always_comb
    begin
        low_fill_next  = low_fill_reg;
        high_fill_next = high_fill_reg;
        status_next    = ST_DONE;
        wr_en          = 1'b0;
        wr_addr        = low_fill_reg[ADDR_W-1:0];
        case (command)
            CMD_PUSH_LOW:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = low_fill_reg[ADDR_W-1:0];
                    low_fill_next = low_fill_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_HIGH:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_addr        = high_push_pos[ADDR_W-1:0];
                    high_fill_next = high_fill_reg + CNT_W'(1);
                end
            end
            CMD_POP_LOW:
            begin
                if (low_fill_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    low_fill_next = low_fill_reg - CNT_W'(1);
                end
            end
            CMD_POP_HIGH:
            begin
                if (high_fill_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    high_fill_next = high_fill_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_fill_reg  <= '0;
            high_fill_reg <= '0;
        end
        else if (cmd.accept)
        begin
            low_fill_reg  <= low_fill_next;
            high_fill_reg <= high_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            rd_low_reg  <= mem[rd_low_addr];
            rd_high_reg <= mem[rd_high_addr];
        end
    end

    assign low_ext    = {{COUNT_W{1'b0}}, low_fill_reg};
    assign high_ext   = {{COUNT_W{1'b0}}, high_fill_reg};
    assign low_count  = low_ext[COUNT_W-1:0];
    assign high_count = high_ext[COUNT_W-1:0];
    assign status     = status_reg;
    assign low_top    = (low_fill_reg == '0) ? '0 : rd_low_reg;
    assign high_top   = (high_fill_reg == '0) ? '0 : rd_high_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_sum <= (CNT_W + 1)'(DEPTH))
        else $error("The two stacks together hold more than the memory.");

    a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && full && (command == CMD_PUSH_LOW || command == CMD_PUSH_HIGH)
        |=> $stable(low_fill_reg) && $stable(high_fill_reg)
            && status_reg == ST_OVERFLOW)
        else $error("A refused push changed a stack.");

    a_underflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && command == CMD_POP_LOW && low_fill_reg == '0
        |=> status_reg == ST_UNDERFLOW && low_fill_reg == '0)
        else $error("A pop of the empty low stack was not refused.");

endmodule

FILE: rtl/dual_stack_shared_memory_top.sv
`timescale 1ns / 1ps
// ============================================================================
// dual_stack_shared_memory_top
// Two stacks in one word memory: the low stack grows up from entry 0, the
// high stack grows down from the last entry.
// ============================================================================
//
// Channel   Handshake         Beat
// --------  ----------------  ------------------------------------------------
// command   start, busy       command, value
// result    done (strobe)     status, low_top, high_top, low_count, high_count
//
// A command is taken when start is high and busy is low. Its result is
// strobed on done after the read state, in which the new tops are read from
// the memory's registered read port. A new command may be taken in the same
// cycle as the result strobe, but not in the read state, while busy is high.
// Reset clears both stacks; the memory itself is not cleared. The receiver
// cannot stall the result.
//
module dual_stack_shared_memory_top
#(
    parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [dssm_pkg::CMD_W-1:0]           command,
    input  logic signed [dssm_pkg::WORD_W-1:0]   value,
    output logic                                 done,
    output logic [dssm_pkg::STATUS_W-1:0]        status,
    output logic signed [dssm_pkg::WORD_W-1:0]   low_top,
    output logic signed [dssm_pkg::WORD_W-1:0]   high_top,
    output logic [dssm_pkg::COUNT_W-1:0]         low_count,
    output logic [dssm_pkg::COUNT_W-1:0]         high_count
);
    import dssm_pkg::*;

    ctrl_cmd_t ctrl_cmd;

    dssm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (ctrl_cmd)
    );

    dssm_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .command    (command),
        .value      (value),
        .status     (status),
        .low_top    (low_top),
        .high_top   (high_top),
        .low_count  (low_count),
        .high_count (high_count)
    );

endmodule
